### rtl/etok_pkg.sv
// ----------------------------------------------------------------------------
// etok_pkg - shared types and constants of the expression tokenizer
// Token kinds, error codes, character codes, lexer modes and the record
// that travels from the front part through the queue to the back part.
// ----------------------------------------------------------------------------
package etok_pkg;

  // Default and limits of the text length
  localparam int MaxTextLenDef = 1024;
  localparam int StartMax      = 1023;
  localparam int LengthMax     = 2047;

  // Depth of the record queue between front and back
  localparam int QueueDepth = 4;

  // Field widths
  localparam int KindW  = 5;
  localparam int StartW = 10;
  localparam int LenW   = 11;
  localparam int ErrW   = 3;

  // Token kinds
  localparam logic [KindW-1:0] K_DONE  = 5'd0;
  localparam logic [KindW-1:0] K_REAL  = 5'd1;
  localparam logic [KindW-1:0] K_NAME  = 5'd2;
  localparam logic [KindW-1:0] K_ADD   = 5'd3;
  localparam logic [KindW-1:0] K_SUB   = 5'd4;
  localparam logic [KindW-1:0] K_MUL   = 5'd5;
  localparam logic [KindW-1:0] K_DIV   = 5'd6;
  localparam logic [KindW-1:0] K_POW   = 5'd7;
  localparam logic [KindW-1:0] K_LPAR  = 5'd8;
  localparam logic [KindW-1:0] K_RPAR  = 5'd9;
  localparam logic [KindW-1:0] K_COMMA = 5'd10;
  localparam logic [KindW-1:0] K_GT    = 5'd11;
  localparam logic [KindW-1:0] K_GE    = 5'd12;
  localparam logic [KindW-1:0] K_LT    = 5'd13;
  localparam logic [KindW-1:0] K_LE    = 5'd14;
  localparam logic [KindW-1:0] K_EQ    = 5'd15;
  localparam logic [KindW-1:0] K_NE    = 5'd16;
  localparam logic [KindW-1:0] K_AND   = 5'd17;
  localparam logic [KindW-1:0] K_OR    = 5'd18;
  localparam logic [KindW-1:0] K_BANG  = 5'd19;
  localparam logic [KindW-1:0] K_ERROR = 5'd20;

  // Error codes
  localparam logic [ErrW-1:0] E_NONE    = 3'd0;
  localparam logic [ErrW-1:0] E_NEWLINE = 3'd1;
  localparam logic [ErrW-1:0] E_NOFRAC  = 3'd2;
  localparam logic [ErrW-1:0] E_NOEXP   = 3'd3;
  localparam logic [ErrW-1:0] E_UNEXP   = 3'd4;
  localparam logic [ErrW-1:0] E_UNKNOWN = 3'd5;
  localparam logic [ErrW-1:0] E_TOOLONG = 3'd6;

  // Character codes
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UPPERE = 8'h45;
  localparam logic [7:0] CH_LOWERE = 8'h65;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  // Lexer modes, one-hot
  typedef enum logic [14:0] {
    M_IDLE    = 15'h0001,
    M_INT     = 15'h0002,
    M_DOT     = 15'h0004,
    M_FRAC    = 15'h0008,
    M_EXP     = 15'h0010,
    M_EXPSIGN = 15'h0020,
    M_EXPDIG  = 15'h0040,
    M_NAME    = 15'h0080,
    M_GT      = 15'h0100,
    M_LT      = 15'h0200,
    M_BANG    = 15'h0400,
    M_EQ      = 15'h0800,
    M_AMP     = 15'h1000,
    M_BAR     = 15'h2000,
    M_HALT    = 15'h4000
  } mode_e;

  // One token
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [StartW-1:0] start;
    logic [LenW-1:0]   length;
    logic [ErrW-1:0]   err;
  } tok_t;

  // All tokens caused by one word: one or two
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } rec_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic tok_t mk_tok(logic [KindW-1:0] kind, logic [StartW-1:0] start,
                                  logic [LenW-1:0] length, logic [ErrW-1:0] err);
    tok_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = length;
    t.err    = err;
    return t;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

endpackage

### rtl/expression_tokenizer_core.sv
// ----------------------------------------------------------------------------
// expression_tokenizer_core - streaming lexer for arithmetic expressions
// One character word in, tokens out as kind, start and length; a front part
// lexes, a record queue decouples, a back part hands out the tokens.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | char_code_i, end_of_text_i
//  out     | output    | out_valid_o/out_stall_i | token_kind_o, token_start_o,
//          |           |                      | token_length_o, error_code_o,
//          |           |                      | last_of_item_o
//
//  The front part takes one character word each cycle while the queue has room;
//  the back part gives one token each cycle while the output is not stalled, so a
//  word that causes two tokens gives them one after the other. A queue of four
//  records lies between them. Input stalls only while that queue is full. Reset
//  clears lexer mode, position, queue pointers and the output valid flag.
// ----------------------------------------------------------------------------
module expression_tokenizer_core #(
  parameter int MaxTextLen = etok_pkg::MaxTextLenDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   char_code_i,
  input  logic                         end_of_text_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [etok_pkg::KindW-1:0]   token_kind_o,
  output logic [etok_pkg::StartW-1:0]  token_start_o,
  output logic [etok_pkg::LenW-1:0]    token_length_o,
  output logic [etok_pkg::ErrW-1:0]    error_code_o,
  output logic                         last_of_item_o
);
  import etok_pkg::*;

  logic    push, pop;
  rec_t    rec_in, rec_head;
  q_stat_t q_stat;
  tok_t    tok;

  etok_front #(
    .MaxTextLen(MaxTextLen)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .end_of_text_i(end_of_text_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .rec_o        (rec_in)
  );

  etok_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .rec_i (rec_in),
    .pop_i (pop),
    .rec_o (rec_head),
    .stat_o(q_stat)
  );

  etok_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_i      (rec_head),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .tok_o      (tok),
    .last_o     (last_of_item_o)
  );

  assign token_kind_o   = tok.kind;
  assign token_start_o  = tok.start;
  assign token_length_o = tok.length;
  assign error_code_o   = tok.err;

endmodule

### rtl/etok_front.sv
// ----------------------------------------------------------------------------
// etok_front - lexer front part
// Accepts one character word per cycle while the queue has room, runs the lexer
// mode machine and pushes any one or two tokens a word causes as a record into the queue.
// ----------------------------------------------------------------------------
module etok_front #(
  parameter int MaxTextLen = etok_pkg::MaxTextLenDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       char_code_i,
  input  logic             end_of_text_i,
  input  etok_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output etok_pkg::rec_t   rec_o
);
  import etok_pkg::*;

  localparam int PosW = $clog2(MaxTextLen + 1);
  localparam int PstW = $clog2(MaxTextLen);
  localparam int ExtW = (PosW > LenW) ? PosW : LenW;

  typedef struct packed {
    mode_e mode;
    logic  emit;
    tok_t  tok;
  } fresh_t;

  mode_e           mode_q, mode_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PstW-1:0] pst_q, pst_d;
  logic            fire;
  logic            e0, e1;
  tok_t            p_tok, f_tok;
  fresh_t          fr;
  logic [PosW-1:0] plen;
  logic [PosW-1:0] last_pos;

  // Saturate a position to the start field
  function automatic logic [StartW-1:0] sat_start(logic [PosW-1:0] v);
    logic [ExtW-1:0] x;
    x = ExtW'(v);
    return (x > ExtW'(StartMax)) ? StartW'(StartMax) : x[StartW-1:0];
  endfunction

  // Saturate a length to the length field
  function automatic logic [LenW-1:0] sat_len(logic [PosW-1:0] v);
    logic [ExtW-1:0] x;
    x = ExtW'(v);
    return (x > ExtW'(LengthMax)) ? LenW'(LengthMax) : x[LenW-1:0];
  endfunction

  // Classify a character that opens a new token
  function automatic fresh_t fresh(logic [7:0] c, logic [StartW-1:0] st);
    fresh_t r;
    r.mode = M_IDLE;
    r.emit = 1'b0;
    r.tok  = mk_tok(K_DONE, st, LenW'(0), E_NONE);
    priority if ((c == CH_SPACE) || (c == CH_TAB)) begin
      r.mode = M_IDLE;
    end else if (c == CH_NL) begin
      r.emit = 1'b1;
      r.tok  = mk_tok(K_ERROR, st, LenW'(0), E_NEWLINE);
      r.mode = M_HALT;
    end else if (is_digit(c)) begin
      r.mode = M_INT;
    end else if (is_alpha(c) || (c == CH_UNDER)) begin
      r.mode = M_NAME;
    end else begin
      unique case (c)
        CH_PLUS:  begin r.emit = 1'b1; r.tok = mk_tok(K_ADD,   st, LenW'(1), E_NONE); end
        CH_MINUS: begin r.emit = 1'b1; r.tok = mk_tok(K_SUB,   st, LenW'(1), E_NONE); end
        CH_STAR:  begin r.emit = 1'b1; r.tok = mk_tok(K_MUL,   st, LenW'(1), E_NONE); end
        CH_SLASH: begin r.emit = 1'b1; r.tok = mk_tok(K_DIV,   st, LenW'(1), E_NONE); end
        CH_CARET: begin r.emit = 1'b1; r.tok = mk_tok(K_POW,   st, LenW'(1), E_NONE); end
        CH_LPAR:  begin r.emit = 1'b1; r.tok = mk_tok(K_LPAR,  st, LenW'(1), E_NONE); end
        CH_RPAR:  begin r.emit = 1'b1; r.tok = mk_tok(K_RPAR,  st, LenW'(1), E_NONE); end
        CH_COMMA: begin r.emit = 1'b1; r.tok = mk_tok(K_COMMA, st, LenW'(1), E_NONE); end
        CH_GT:    r.mode = M_GT;
        CH_LT:    r.mode = M_LT;
        CH_BANG:  r.mode = M_BANG;
        CH_EQ:    r.mode = M_EQ;
        CH_AMP:   r.mode = M_AMP;
        CH_BAR:   r.mode = M_BAR;
        default: begin
          r.emit = 1'b1;
          r.tok  = mk_tok(K_ERROR, st, LenW'(0), E_UNKNOWN);
          r.mode = M_HALT;
        end
      endcase
    end
    return r;
  endfunction

  // Stall while the queue has no room
  assign in_stall_o = q_stat_i.full;
  assign fire       = in_valid_i && !in_stall_o;

  assign plen     = pos_q - PosW'(pst_q);
  assign last_pos = (pos_q != '0) ? pos_q - PosW'(1) : '0;
  assign fr       = fresh(char_code_i, sat_start(pos_q));

  // Next mode and the tokens of this word: pending one first, own one second
  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    pst_d  = pst_q;
    e0     = 1'b0;
    e1     = 1'b0;
    p_tok  = mk_tok(K_DONE, sat_start(PosW'(pst_q)), LenW'(0), E_NONE);
    f_tok  = fr.tok;
    if (fire) begin
      if (end_of_text_i) begin
        // Flush the pending token, then done
        e0 = 1'b1;
        unique case (mode_q)
          M_INT, M_FRAC, M_EXPDIG:
            p_tok = mk_tok(K_REAL, sat_start(PosW'(pst_q)), sat_len(plen), E_NONE);
          M_NAME:
            p_tok = mk_tok(K_NAME, sat_start(PosW'(pst_q)), sat_len(plen), E_NONE);
          M_GT:   p_tok = mk_tok(K_GT,   sat_start(PosW'(pst_q)), LenW'(1), E_NONE);
          M_LT:   p_tok = mk_tok(K_LT,   sat_start(PosW'(pst_q)), LenW'(1), E_NONE);
          M_BANG: p_tok = mk_tok(K_BANG, sat_start(PosW'(pst_q)), LenW'(1), E_NONE);
          M_DOT:  p_tok = mk_tok(K_ERROR, sat_start(last_pos), LenW'(0), E_NOFRAC);
          M_EXP, M_EXPSIGN:
            p_tok = mk_tok(K_ERROR, sat_start(last_pos), LenW'(0), E_NOEXP);
          M_EQ, M_AMP, M_BAR:
            p_tok = mk_tok(K_ERROR, sat_start(last_pos), LenW'(0), E_UNEXP);
          default: e0 = 1'b0;
        endcase
        e1     = 1'b1;
        f_tok  = mk_tok(K_DONE, sat_start(pos_q), LenW'(0), E_NONE);
        mode_d = M_IDLE;
        pos_d  = '0;
        pst_d  = '0;
      end else if (mode_q == M_HALT) begin
        // Drop characters until the end marker
        mode_d = M_HALT;
      end else if (pos_q >= PosW'(MaxTextLen)) begin
        e1     = 1'b1;
        f_tok  = mk_tok(K_ERROR, sat_start(pos_q), LenW'(0), E_TOOLONG);
        mode_d = M_HALT;
      end else begin
        unique case (mode_q)
          M_INT, M_FRAC: begin
            if (is_digit(char_code_i)) begin
              mode_d = mode_q;
            end else if ((char_code_i == CH_DOT) && (mode_q == M_INT)) begin
              mode_d = M_DOT;
            end else if ((char_code_i == CH_LOWERE) || (char_code_i == CH_UPPERE)) begin
              mode_d = M_EXP;
            end else begin
              e0     = 1'b1;
              p_tok  = mk_tok(K_REAL, sat_start(PosW'(pst_q)), sat_len(plen), E_NONE);
              e1     = fr.emit;
              mode_d = fr.mode;
              pst_d  = pos_q[PstW-1:0];
            end
          end
          M_DOT: begin
            if (is_digit(char_code_i)) begin
              mode_d = M_FRAC;
            end else begin
              e1     = 1'b1;
              f_tok  = mk_tok(K_ERROR, sat_start(pos_q), LenW'(0), E_NOFRAC);
              mode_d = M_HALT;
            end
          end
          M_EXP, M_EXPSIGN: begin
            if (is_digit(char_code_i)) begin
              mode_d = M_EXPDIG;
            end else if ((mode_q == M_EXP) &&
                         ((char_code_i == CH_PLUS) || (char_code_i == CH_MINUS))) begin
              mode_d = M_EXPSIGN;
            end else begin
              e1     = 1'b1;
              f_tok  = mk_tok(K_ERROR, sat_start(pos_q), LenW'(0), E_NOEXP);
              mode_d = M_HALT;
            end
          end
          M_EXPDIG, M_NAME: begin
            if ((mode_q == M_EXPDIG) ? is_digit(char_code_i) : is_word(char_code_i)) begin
              mode_d = mode_q;
            end else begin
              e0     = 1'b1;
              p_tok  = mk_tok((mode_q == M_NAME) ? K_NAME : K_REAL,
                              sat_start(PosW'(pst_q)), sat_len(plen), E_NONE);
              e1     = fr.emit;
              mode_d = fr.mode;
              pst_d  = pos_q[PstW-1:0];
            end
          end
          M_GT, M_LT, M_BANG: begin
            e0 = 1'b1;
            if (char_code_i == CH_EQ) begin
              p_tok  = mk_tok((mode_q == M_GT) ? K_GE : (mode_q == M_LT) ? K_LE : K_NE,
                              sat_start(PosW'(pst_q)), LenW'(2), E_NONE);
              mode_d = M_IDLE;
            end else begin
              p_tok  = mk_tok((mode_q == M_GT) ? K_GT : (mode_q == M_LT) ? K_LT : K_BANG,
                              sat_start(PosW'(pst_q)), LenW'(1), E_NONE);
              e1     = fr.emit;
              mode_d = fr.mode;
              pst_d  = pos_q[PstW-1:0];
            end
          end
          M_EQ, M_AMP, M_BAR: begin
            if (((mode_q == M_EQ) && (char_code_i == CH_EQ)) ||
                ((mode_q == M_AMP) && (char_code_i == CH_AMP)) ||
                ((mode_q == M_BAR) && (char_code_i == CH_BAR))) begin
              e0     = 1'b1;
              p_tok  = mk_tok((mode_q == M_EQ) ? K_EQ : (mode_q == M_AMP) ? K_AND : K_OR,
                              sat_start(PosW'(pst_q)), LenW'(2), E_NONE);
              mode_d = M_IDLE;
            end else begin
              e1     = 1'b1;
              f_tok  = mk_tok(K_ERROR, sat_start(pos_q), LenW'(0), E_UNEXP);
              mode_d = M_HALT;
            end
          end
          default: begin
            // Idle between tokens
            e1     = fr.emit;
            mode_d = fr.mode;
            pst_d  = pos_q[PstW-1:0];
          end
        endcase
        if (mode_d != M_HALT) begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  // Pack the record, moving a lone own token into the first slot
  assign push_o     = e0 || e1;
  assign rec_o.two  = e0 && e1;
  assign rec_o.tok0 = e0 ? p_tok : f_tok;
  assign rec_o.tok1 = f_tok;

  // Hold the lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pos_q  <= '0;
      pst_q  <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      pst_q  <= pst_d;
    end
  end

endmodule

### rtl/etok_queue.sv
// ----------------------------------------------------------------------------
// etok_queue - record queue between front and back
// A short first-in first-out store of token records with registered status.
// ----------------------------------------------------------------------------
module etok_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  etok_pkg::rec_t    rec_i,
  input  logic              pop_i,
  output etok_pkg::rec_t    rec_o,
  output etok_pkg::q_stat_t stat_o
);
  import etok_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  rec_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign do_push = push_i && (cnt_q != CntW'(QueueDepth));
  assign do_pop  = pop_i && (cnt_q != '0);

  // Advance pointers and count
  always_comb begin
    wr_d  = do_push ? wr_q + PtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the record
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  assign rec_o        = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

### rtl/etok_back.sv
// ----------------------------------------------------------------------------
// etok_back - token output part
// Takes the head record of the queue apart, one token a cycle while the output
// is not stalled, into the output register, and marks the last token of each word.
// ----------------------------------------------------------------------------
module etok_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  etok_pkg::rec_t    rec_i,
  input  etok_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output etok_pkg::tok_t    tok_o,
  output logic              last_o
);
  import etok_pkg::*;

  logic valid_q, valid_d;
  logic sel_q, sel_d;
  tok_t tok_q, tok_d;
  logic last_q, last_d;
  logic load;
  logic head_last;

  assign load      = !valid_q || !out_stall_i;
  assign head_last = !(rec_i.two && !sel_q);

  // Load the next token when the output register frees
  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    tok_d   = tok_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        tok_d  = sel_q ? rec_i.tok1 : rec_i.tok0;
        last_d = head_last;
        pop_o  = head_last;
        sel_d  = !head_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  // Hold the payload
  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign tok_o       = tok_q;
  assign last_o      = last_q;

endmodule

### rtl/etok_checker.sv
// ----------------------------------------------------------------------------
// etok_checker - port checks of the expression tokenizer
// Watches the output channel of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
module etok_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [etok_pkg::KindW-1:0]  token_kind_o,
  input logic [etok_pkg::StartW-1:0] token_start_o,
  input logic [etok_pkg::LenW-1:0]   token_length_o,
  input logic [etok_pkg::ErrW-1:0]   error_code_o,
  input logic                        last_of_item_o
);
  import etok_pkg::*;

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(token_start_o) && $stable(token_length_o) &&
      $stable(error_code_o) && $stable(last_of_item_o))
    else $error("stalled token changed");

  // Done closes its word and carries no length
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == K_DONE) |->
      last_of_item_o && (token_length_o == '0) && (error_code_o == E_NONE))
    else $error("malformed done token");

  // An error code appears exactly on error tokens, with no length
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((token_kind_o == K_ERROR) == (error_code_o != E_NONE)) &&
      ((token_kind_o != K_ERROR) || (token_length_o == '0)))
    else $error("error code and kind disagree");

  // Every real token spans characters
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o != K_DONE) && (token_kind_o != K_ERROR) |->
      (token_length_o != '0) && (token_kind_o < K_ERROR))
    else $error("empty or unknown token");

endmodule

bind expression_tokenizer_core etok_checker u_etok_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .token_kind_o  (token_kind_o),
  .token_start_o (token_start_o),
  .token_length_o(token_length_o),
  .error_code_o  (error_code_o),
  .last_of_item_o(last_of_item_o)
);

### sim/expression_tokenizer_core_checker.sv
// ----------------------------------------------------------------------------
// expression_tokenizer_core_checker - token predictor and scoreboard
// Watches both channels of the tokenizer. Each accepted character word is run
// through a local lexer that builds the tokens it causes. Each token handed
// out is compared field by field with the oldest of those.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module expression_tokenizer_core_checker #(
  parameter int MaxTextLen = etok_pkg::MaxTextLenDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [7:0]                  char_code_i,
  input  logic                        end_of_text_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [etok_pkg::KindW-1:0]  token_kind_i,
  input  logic [etok_pkg::StartW-1:0] token_start_i,
  input  logic [etok_pkg::LenW-1:0]   token_length_i,
  input  logic [etok_pkg::ErrW-1:0]   error_code_i,
  input  logic                        last_of_item_i,
  output int                          fail_count_o,
  output int                          due_count_o,
  output int                          checked_count_o
);
  import etok_pkg::*;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [StartW-1:0] start;
    logic [LenW-1:0]   length;
    logic [ErrW-1:0]   err;
    logic              last;
  } token_t;

  // Tokens predicted but not yet seen on the output
  token_t due_tokens[$];

  // Local lexer state
  mode_e       lex_mode;
  int unsigned char_pos;
  int unsigned tok_begin;

  function automatic bit digit_char(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic bit letter_char(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Queue one token, saturating start and length at the port widths
  task automatic post_token(input logic [KindW-1:0] kind, input int unsigned start,
                            input int unsigned len, input logic [ErrW-1:0] code);
    token_t t;
    t.kind   = kind;
    t.start  = (start > StartMax) ? StartW'(StartMax) : StartW'(start);
    t.length = (len > LengthMax) ? LenW'(LengthMax) : LenW'(len);
    t.err    = code;
    t.last   = 1'b0;
    due_tokens.push_back(t);
  endtask

  task automatic raise_error(input int unsigned pos, input logic [ErrW-1:0] code);
    post_token(K_ERROR, pos, 0, code);
    lex_mode = M_HALT;
  endtask

  // Start a new token on character c at position pos
  task automatic open_token(input logic [7:0] c, input int unsigned pos);
    lex_mode  = M_IDLE;
    tok_begin = pos;
    if (c == CH_SPACE || c == CH_TAB) begin
    end else if (c == CH_NL) begin
      raise_error(pos, E_NEWLINE);
    end else if (digit_char(c)) begin
      lex_mode = M_INT;
    end else if (letter_char(c) || c == CH_UNDER) begin
      lex_mode = M_NAME;
    end else begin
      case (c)
        CH_PLUS:  post_token(K_ADD, pos, 1, E_NONE);
        CH_MINUS: post_token(K_SUB, pos, 1, E_NONE);
        CH_STAR:  post_token(K_MUL, pos, 1, E_NONE);
        CH_SLASH: post_token(K_DIV, pos, 1, E_NONE);
        CH_CARET: post_token(K_POW, pos, 1, E_NONE);
        CH_LPAR:  post_token(K_LPAR, pos, 1, E_NONE);
        CH_RPAR:  post_token(K_RPAR, pos, 1, E_NONE);
        CH_COMMA: post_token(K_COMMA, pos, 1, E_NONE);
        CH_GT:    lex_mode = M_GT;
        CH_LT:    lex_mode = M_LT;
        CH_BANG:  lex_mode = M_BANG;
        CH_EQ:    lex_mode = M_EQ;
        CH_AMP:   lex_mode = M_AMP;
        CH_BAR:   lex_mode = M_BAR;
        default:  raise_error(pos, E_UNKNOWN);
      endcase
    end
  endtask

  // Advance the lexer by one word and queue the tokens it causes
  task automatic lex_word(input logic [7:0] c, input logic eot);
    int unsigned      pos;
    int unsigned      plen;
    int unsigned      last_pos;
    int               before_n;
    logic [KindW-1:0] k_one;
    logic [KindW-1:0] k_two;
    logic [7:0]       partner;
    token_t           t;
    pos      = char_pos;
    plen     = pos - tok_begin;
    before_n = due_tokens.size();
    if (eot) begin
      // flush whatever is pending, then done
      last_pos = (pos > 0) ? pos - 1 : 0;
      case (lex_mode)
        M_INT, M_FRAC, M_EXPDIG: post_token(K_REAL, tok_begin, plen, E_NONE);
        M_NAME:              post_token(K_NAME, tok_begin, plen, E_NONE);
        M_GT:                post_token(K_GT, tok_begin, 1, E_NONE);
        M_LT:                post_token(K_LT, tok_begin, 1, E_NONE);
        M_BANG:              post_token(K_BANG, tok_begin, 1, E_NONE);
        M_DOT:               post_token(K_ERROR, last_pos, 0, E_NOFRAC);
        M_EXP, M_EXPSIGN:    post_token(K_ERROR, last_pos, 0, E_NOEXP);
        M_EQ, M_AMP, M_BAR:  post_token(K_ERROR, last_pos, 0, E_UNEXP);
        default: ;
      endcase
      post_token(K_DONE, pos, 0, E_NONE);
      lex_mode  = M_IDLE;
      char_pos  = 0;
      tok_begin = 0;
    end else if (lex_mode == M_HALT) begin
      // drop characters until the end marker
    end else if (pos >= MaxTextLen) begin
      raise_error(pos, E_TOOLONG);
    end else begin
      case (lex_mode)
        M_INT: begin
          if (digit_char(c)) begin
          end else if (c == CH_DOT) begin
            lex_mode = M_DOT;
          end else if (c == CH_LOWERE || c == CH_UPPERE) begin
            lex_mode = M_EXP;
          end else begin
            post_token(K_REAL, tok_begin, plen, E_NONE);
            open_token(c, pos);
          end
        end
        M_DOT: begin
          if (digit_char(c)) lex_mode = M_FRAC;
          else raise_error(pos, E_NOFRAC);
        end
        M_FRAC: begin
          if (digit_char(c)) begin
          end else if (c == CH_LOWERE || c == CH_UPPERE) begin
            lex_mode = M_EXP;
          end else begin
            post_token(K_REAL, tok_begin, plen, E_NONE);
            open_token(c, pos);
          end
        end
        M_EXP: begin
          if (c == CH_PLUS || c == CH_MINUS) lex_mode = M_EXPSIGN;
          else if (digit_char(c)) lex_mode = M_EXPDIG;
          else raise_error(pos, E_NOEXP);
        end
        M_EXPSIGN: begin
          if (digit_char(c)) lex_mode = M_EXPDIG;
          else raise_error(pos, E_NOEXP);
        end
        M_EXPDIG: begin
          if (!digit_char(c)) begin
            post_token(K_REAL, tok_begin, plen, E_NONE);
            open_token(c, pos);
          end
        end
        M_NAME: begin
          if (!(letter_char(c) || digit_char(c) || c == CH_UNDER)) begin
            post_token(K_NAME, tok_begin, plen, E_NONE);
            open_token(c, pos);
          end
        end
        M_GT, M_LT, M_BANG: begin
          // single operator unless '=' follows
          k_one = (lex_mode == M_GT) ? K_GT : (lex_mode == M_LT) ? K_LT : K_BANG;
          k_two = (lex_mode == M_GT) ? K_GE : (lex_mode == M_LT) ? K_LE : K_NE;
          if (c == CH_EQ) begin
            post_token(k_two, tok_begin, 2, E_NONE);
            lex_mode = M_IDLE;
          end else begin
            post_token(k_one, tok_begin, 1, E_NONE);
            open_token(c, pos);
          end
        end
        M_EQ, M_AMP, M_BAR: begin
          // these need their partner character
          partner = (lex_mode == M_EQ) ? CH_EQ : (lex_mode == M_AMP) ? CH_AMP : CH_BAR;
          k_two   = (lex_mode == M_EQ) ? K_EQ : (lex_mode == M_AMP) ? K_AND : K_OR;
          if (c == partner) begin
            post_token(k_two, tok_begin, 2, E_NONE);
            lex_mode = M_IDLE;
          end else begin
            raise_error(pos, E_UNEXP);
          end
        end
        default: open_token(c, pos);
      endcase
      if (lex_mode != M_HALT) char_pos = pos + 1;
    end
    // mark the final token of this word
    if (due_tokens.size() > before_n) begin
      t      = due_tokens.pop_back();
      t.last = 1'b1;
      due_tokens.push_back(t);
    end
  endtask

  // Predict on accepted input words, compare on accepted output words
  always @(posedge clk_i or negedge rst_ni) begin : watch
    token_t want;
    if (!rst_ni) begin
      lex_mode  = M_IDLE;
      char_pos  = 0;
      tok_begin = 0;
      due_tokens.delete();
      fail_count_o    = 0;
      checked_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) lex_word(char_code_i, end_of_text_i);
      if (out_valid_i && !out_stall_i) begin
        if (due_tokens.size() == 0) begin
          $error("token with no expectation: kind %0d start %0d length %0d",
                 token_kind_i, token_start_i, token_length_i);
          fail_count_o++;
        end else begin
          want = due_tokens.pop_front();
          checked_count_o++;
          if (token_kind_i !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, token_kind_i);
            fail_count_o++;
          end
          if (token_start_i !== want.start) begin
            $error("token_start: expected %0d, got %0d", want.start, token_start_i);
            fail_count_o++;
          end
          if (token_length_i !== want.length) begin
            $error("token_length: expected %0d, got %0d", want.length, token_length_i);
            fail_count_o++;
          end
          if (error_code_i !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, error_code_i);
            fail_count_o++;
          end
          if (last_of_item_i !== want.last) begin
            $error("last_of_item: expected %0d, got %0d", want.last, last_of_item_i);
            fail_count_o++;
          end
        end
      end
    end
    due_count_o = due_tokens.size();
  end

endmodule

### sim/expression_tokenizer_core_test.sv
// ----------------------------------------------------------------------------
// expression_tokenizer_core_test - stimulus and verdict for the tokenizer
// Feeds short directed texts, then random expressions built from numbers,
// names, operators, blanks and some broken or foreign characters, then one
// text that overruns the length limit, under changing idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module expression_tokenizer_core_test;
  import etok_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int RandomWords = 400;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 16;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        char_code = 8'h00;
  logic              eot = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KindW-1:0]  token_kind;
  logic [StartW-1:0] token_start;
  logic [LenW-1:0]   token_length;
  logic [ErrW-1:0]   error_code;
  logic              last_of_item;

  int fail_count;
  int due_count;
  int checked_count;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int words_sent = 0;
  int texts_sent = 0;
  int cycle_count = 0;

  // Characters of the text being built
  logic [7:0] text_q[$];

  expression_tokenizer_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .char_code_i    (char_code),
    .end_of_text_i  (eot),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .token_kind_o   (token_kind),
    .token_start_o  (token_start),
    .token_length_o (token_length),
    .error_code_o   (error_code),
    .last_of_item_o (last_of_item)
  );

  expression_tokenizer_core_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .char_code_i     (char_code),
    .end_of_text_i   (eot),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .token_kind_i    (token_kind),
    .token_start_i   (token_start),
    .token_length_i  (token_length),
    .error_code_i    (error_code),
    .last_of_item_i  (last_of_item),
    .fail_count_o    (fail_count),
    .due_count_o     (due_count),
    .checked_count_o (checked_count)
  );

  always #6 clk = ~clk;

  // End the run if it hangs
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("expression_tokenizer_core_test: done, errors");
    $finish;
  end

  // Receiver: random stalls, or a long hold when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk);
        holds_served++;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_word(input logic [7:0] c, input logic e);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    eot       <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Send the built text followed by the end marker with a random code
  task automatic send_text();
    foreach (text_q[i]) send_word(text_q[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
    texts_sent++;
    text_q.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_pick(input string set);
    text_q.push_back(set[$urandom_range(0, set.len() - 1)]);
  endtask

  // Append one random lexeme, mostly well formed
  task automatic add_piece();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      repeat ($urandom_range(1, 3)) add_pick("0123456789");
      if ($urandom_range(0, 99) < 40) begin
        text_q.push_back(CH_DOT);
        repeat ($urandom_range(1, 3)) add_pick("0123456789");
      end
      if ($urandom_range(0, 99) < 30) begin
        add_pick("eE");
        if ($urandom_range(0, 1)) add_pick("+-");
        repeat ($urandom_range(1, 2)) add_pick("0123456789");
      end
    end else if (r < 55) begin
      add_pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_");
      repeat ($urandom_range(0, 5))
        add_pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789");
    end else if (r < 70) begin
      add_pick("+-*/^(),");
    end else if (r < 85) begin
      case ($urandom_range(0, 8))
        0: add_str(">=");
        1: add_str("<=");
        2: add_str("==");
        3: add_str("!=");
        4: add_str("&&");
        5: add_str("||");
        6: add_str(">");
        7: add_str("<");
        default: add_str("!");
      endcase
    end else if (r < 92) begin
      add_pick(" \t");
    end else if (r < 97) begin
      // broken sequences; the next lexeme may or may not complete them
      case ($urandom_range(0, 6))
        0: add_str("1.");
        1: add_str("7e");
        2: add_str("7E-");
        3: add_str("=");
        4: add_str("&");
        5: add_str("|");
        default: text_q.push_back(CH_NL);
      endcase
    end else begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Random texts until the word budget of a phase is spent
  task automatic run_random(input int budget);
    int target;
    target = words_sent + budget;
    while (words_sent < target) begin
      repeat ($urandom_range(1, 10)) begin
        add_piece();
        if ($urandom_range(0, 1)) text_q.push_back(CH_SPACE);
      end
      send_text();
    end
  endtask

  initial begin
    // Hold reset, then release on a clock edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty text, mixed tokens, flush errors, foreign bytes, halt
    send_text();
    add_str("x>=1.5e-3");
    send_text();
    add_str("1.");
    send_text();
    add_str("&");
    send_text();
    text_q.push_back(8'h00);
    add_str("a");
    send_text();
    text_q.push_back(8'hFF);
    send_text();
    text_q.push_back(CH_NL);
    send_text();

    // Random: no idling with a long output hold, then the idle mixes
    hold_requests++;
    run_random(RandomWords / 4);
    tx_idle_pct  = 69;
    run_random(RandomWords / 4);
    tx_idle_pct  = 0;
    rx_stall_pct = 69;
    run_random(RandomWords / 4);
    tx_idle_pct  = 31;
    rx_stall_pct = 31;
    run_random(RandomWords / 4);

    // Length limit: a name filling every position, overrun by two more characters
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    add_pick("ABCDEFGHIJKLMNOPQRSTUVWXYZ_");
    repeat (MaxTextLenDef + 1) add_pick("abcdefghijklmnopqrstuvwxyz_0123456789");
    send_text();

    // Drain the output and give the block time to settle
    in_valid <= 1'b0;
    while (due_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("run covered %0d texts in %0d words, %0d tokens compared,", texts_sent,
             words_sent, checked_count);
    $display("four idle mixes, a %0d-cycle output hold and one overlong text",
             HoldCycles);
    if (fail_count == 0) begin
      $display("expression_tokenizer_core_test: done, clean");
    end else begin
      $display("expression_tokenizer_core_test: done, errors");
    end
    $finish;
  end

endmodule

### expression_tokenizer_core.f
rtl/etok_pkg.sv
rtl/etok_front.sv
rtl/etok_queue.sv
rtl/etok_back.sv
rtl/expression_tokenizer_core.sv
rtl/etok_checker.sv
sim/expression_tokenizer_core_checker.sv
sim/expression_tokenizer_core_test.sv
